// ===== rtl/core/whcrr_pkg.sv =====
// shared types, constants and tag tables for the wav header checker
// used by every module of the block; depends on nothing

package whcrr_pkg;

   // header layout
   localparam logic [5:0] HdrLen = 6'd44;

   // operating modes
   localparam logic [1:0] ModeCheck  = 2'd1;
   localparam logic [1:0] ModeHalve  = 2'd2;
   localparam logic [1:0] ModeDouble = 2'd3;

   // configuration register map (word index above the byte offset)
   localparam int unsigned CsrAddrW = 3;
   localparam logic [0:0] RegMode = 1'b0;

   // status codes
   localparam logic [3:0] StOk         = 4'd0;
   localparam logic [3:0] StRiff       = 4'd1;
   localparam logic [3:0] StWave       = 4'd2;
   localparam logic [3:0] StFmtTag     = 4'd3;
   localparam logic [3:0] StFmtSize    = 4'd4;
   localparam logic [3:0] StNotPcm     = 4'd5;
   localparam logic [3:0] StChannels   = 4'd6;
   localparam logic [3:0] StByteRate   = 4'd7;
   localparam logic [3:0] StBlockAlign = 4'd8;
   localparam logic [3:0] StFileSize   = 4'd9;
   localparam logic [3:0] StTrunc      = 4'd10;

   // queue between front and back
   localparam int unsigned QDepth = 4;
   localparam int unsigned QPtrW  = $clog2(QDepth);

   // one input byte's worth of results: one to four beats
   typedef struct packed {
      logic [1:0]      last_idx;
      logic            data_ok;
      logic [3:0]      status;
      logic [3:0][7:0] bytes;
   } job_type;

   // expected tag byte at a header position (1-based)
   function automatic logic [7:0] tag_byte(input logic [5:0] pos);
      logic [7:0] t;
      unique case (pos)
         6'd1:    t = 8'd82;
         6'd2:    t = 8'd73;
         6'd3:    t = 8'd70;
         6'd4:    t = 8'd70;
         6'd9:    t = 8'd87;
         6'd10:   t = 8'd65;
         6'd11:   t = 8'd86;
         6'd12:   t = 8'd69;
         6'd13:   t = 8'd102;
         6'd14:   t = 8'd109;
         6'd15:   t = 8'd116;
         6'd16:   t = 8'd32;
         6'd37:   t = 8'd100;
         6'd38:   t = 8'd97;
         6'd39:   t = 8'd116;
         6'd40:   t = 8'd97;
         default: t = 8'd0;
      endcase
      return t;
   endfunction

   // error raised by a wrong tag byte, StOk where the position holds no tag
   function automatic logic [3:0] tag_status(input logic [5:0] pos);
      logic [3:0] s;
      unique case (pos)
         6'd1, 6'd2, 6'd3, 6'd4:     s = StRiff;
         6'd9, 6'd10, 6'd11, 6'd12:  s = StWave;
         6'd13, 6'd14, 6'd15, 6'd16: s = StFmtTag;
         6'd37, 6'd38, 6'd39, 6'd40: s = StFmtTag;
         default:                    s = StOk;
      endcase
      return s;
   endfunction

endpackage

// ===== rtl/core/whcrr_front.sv =====
// front end: takes file bytes, parses and checks the header, builds result jobs
// depends on whcrr_pkg

module whcrr_front (
   input  logic                clock,
   input  logic                reset,
   input  logic [1:0]          mode,
   input  logic                req_tvalid,
   output logic                req_tready,
   input  logic [7:0]          req_tdata,   // [7:0] in_byte
   input  logic                req_tlast,   // end_of_file
   input  logic                q_full,
   output logic                q_push,
   output whcrr_pkg::job_type  q_job
);

   logic [5:0]       bp_ff, bp_in;
   logic             halted_ff, halted_in;
   logic [31:0]      total_ff, total_in, total_inc;
   logic [32:0]      expect_ff, expect_in;
   logic [3:0][7:0]  riff_ff, riff_in;
   logic [3:0][7:0]  fmt_ff, fmt_in;
   logic [1:0][7:0]  af_ff, af_in;
   logic [1:0][7:0]  ch_ff, ch_in;
   logic [3:0][7:0]  sr_ff, sr_in;
   logic [3:0][7:0]  br_ff, br_in;
   logic [1:0][7:0]  ba_ff, ba_in;
   logic [1:0][7:0]  bps_ff, bps_in;
   logic [39:0]      partial_ff, partial_in;

   logic             accept, copy, dbl, eof, halt_set, mid;
   logic [7:0]       b;
   logic [5:0]       pos;
   logic [3:0]       chk, st;
   logic [2:0]       n;
   logic [3:0][7:0]  bytes;
   logic [31:0]      rate_src, rw;
   logic [39:0]      mul;
   logic [47:0]      prod;
   logic [15:0]      bps_word;
   logic [13:0]      need;

   assign req_tready = !q_full;
   assign accept     = req_tvalid && !q_full;
   assign b          = req_tdata;
   assign eof        = req_tlast;
   assign copy       = (mode == whcrr_pkg::ModeHalve) || (mode == whcrr_pkg::ModeDouble);
   assign dbl        = (mode == whcrr_pkg::ModeDouble);
   assign pos        = bp_ff + 6'd1;
   assign mid        = (pos >= 6'd25) && (pos <= 6'd36);
   assign total_inc  = (total_ff == 32'hFFFF_FFFF) ? total_ff : total_ff + 32'd1;

   // rate rewrite on the fourth byte of sample rate or byte rate
   assign rate_src = (pos == 6'd28) ? {b, sr_ff[2], sr_ff[1], sr_ff[0]}
                                    : {b, br_ff[2], br_ff[1], br_ff[0]};
   assign rw       = dbl ? {rate_src[30:0], 1'b0} : {1'b0, rate_src[31:1]};

   // sample rate times block align, one byte of block align per cycle in which a byte is accepted
   assign mul  = 40'(sr_ff) * 40'(b);
   assign prod = {8'd0, partial_ff} + {mul, 8'd0};

   // channel count is already known to be 1 or 2 here
   assign bps_word = {b, bps_ff[0]};
   assign need     = (ch_ff[0] == 8'd2) ? {bps_word[15:3], 1'b0} : {1'b0, bps_word[15:3]};

   always_comb begin
      bp_in      = bp_ff;
      halted_in  = halted_ff;
      total_in   = total_ff;
      expect_in  = expect_ff;
      riff_in    = riff_ff;
      fmt_in     = fmt_ff;
      af_in      = af_ff;
      ch_in      = ch_ff;
      sr_in      = sr_ff;
      br_in      = br_ff;
      ba_in      = ba_ff;
      bps_in     = bps_ff;
      partial_in = partial_ff;
      chk        = whcrr_pkg::StOk;
      st         = whcrr_pkg::StOk;
      n          = 3'd0;
      bytes      = '0;
      halt_set   = 1'b0;
      if (accept) begin
         total_in = total_inc;
         if (halted_ff) begin
            if (copy) begin
               bytes[0] = b;
               n        = 3'd1;
            end
         end else if (bp_ff < whcrr_pkg::HdrLen) begin
            bp_in = pos;
            priority if (whcrr_pkg::tag_status(pos) != whcrr_pkg::StOk) begin
               if (b != whcrr_pkg::tag_byte(pos)) chk = whcrr_pkg::tag_status(pos);
            end else if (pos <= 6'd8) begin
               riff_in[bp_ff[1:0]] = b;
               if (pos == 6'd8) expect_in = {1'b0, b, riff_ff[2], riff_ff[1], riff_ff[0]} + 33'd8;
            end else if (pos <= 6'd20) begin
               fmt_in[bp_ff[1:0]] = b;
               if (pos == 6'd20 && {b, fmt_ff[2], fmt_ff[1], fmt_ff[0]} != 32'd16)
                  chk = whcrr_pkg::StFmtSize;
            end else if (pos <= 6'd22) begin
               af_in[bp_ff[0]] = b;
               if (pos == 6'd22 && {b, af_ff[0]} != 16'd1) chk = whcrr_pkg::StNotPcm;
            end else if (pos <= 6'd24) begin
               ch_in[bp_ff[0]] = b;
               if (pos == 6'd24 && {b, ch_ff[0]} != 16'd1 && {b, ch_ff[0]} != 16'd2)
                  chk = whcrr_pkg::StChannels;
            end else if (pos <= 6'd28) begin
               sr_in[bp_ff[1:0]] = b;
            end else if (pos <= 6'd32) begin
               br_in[bp_ff[1:0]] = b;
            end else if (pos <= 6'd34) begin
               ba_in[bp_ff[0]] = b;
               if (pos == 6'd33) partial_in = mul;
               if (pos == 6'd34 && {16'd0, br_ff} != prod) chk = whcrr_pkg::StByteRate;
            end else if (pos <= 6'd36) begin
               bps_in[bp_ff[0]] = b;
               if (pos == 6'd36 && ba_ff != {2'b00, need}) chk = whcrr_pkg::StBlockAlign;
            end else begin
               chk = whcrr_pkg::StOk;
            end
            // block align and bits per sample go out before their check
            if (copy && pos >= 6'd33 && pos <= 6'd36) begin
               bytes[0] = b;
               n        = 3'd1;
            end
            st = chk;
            if (chk != whcrr_pkg::StOk) begin
               halt_set = 1'b1;
            end else begin
               if (copy && !mid) begin
                  bytes[0] = b;
                  n        = 3'd1;
               end
               if (copy && (pos == 6'd28 || pos == 6'd32)) begin
                  bytes = rw;
                  n     = 3'd4;
               end
               if (pos == whcrr_pkg::HdrLen && !copy && eof && {1'b0, total_inc} != expect_ff)
                  st = whcrr_pkg::StFileSize;
               if (pos < whcrr_pkg::HdrLen && eof) st = whcrr_pkg::StTrunc;
            end
         end else begin
            if (copy) begin
               bytes[0] = b;
               n        = 3'd1;
            end else if ({1'b0, total_inc} > expect_ff) begin
               st       = whcrr_pkg::StFileSize;
               halt_set = 1'b1;
            end else if (eof && {1'b0, total_inc} != expect_ff) begin
               st = whcrr_pkg::StFileSize;
            end
         end
         halted_in = halted_ff || halt_set;
         if (eof) begin
            bp_in     = 6'd0;
            halted_in = 1'b0;
            total_in  = 32'd0;
         end
      end
   end

   assign q_push         = accept;
   assign q_job.bytes    = bytes;
   assign q_job.status   = st;
   assign q_job.data_ok  = (n != 3'd0);
   assign q_job.last_idx = (n == 3'd0) ? 2'd0 : 2'(n - 3'd1);

   always_ff @(posedge clock) begin
      if (reset) begin
         bp_ff     <= 6'd0;
         halted_ff <= 1'b0;
         total_ff  <= 32'd0;
      end else begin
         bp_ff     <= bp_in;
         halted_ff <= halted_in;
         total_ff  <= total_in;
      end
   end

   always_ff @(posedge clock) begin
      expect_ff  <= expect_in;
      riff_ff    <= riff_in;
      fmt_ff     <= fmt_in;
      af_ff      <= af_in;
      ch_ff      <= ch_in;
      sr_ff      <= sr_in;
      br_ff      <= br_in;
      ba_ff      <= ba_in;
      bps_ff     <= bps_in;
      partial_ff <= partial_in;
   end

endmodule

// ===== rtl/core/whcrr_queue.sv =====
// short job queue between the front end and the result sequencer
// depends on whcrr_pkg

module whcrr_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  whcrr_pkg::job_type  push_job,
   output logic                full,
   input  logic                pop,
   output logic                empty,
   output whcrr_pkg::job_type  head
);

   whcrr_pkg::job_type          mem_ff [whcrr_pkg::QDepth];
   logic [whcrr_pkg::QPtrW-1:0] wr_ff, wr_in, rd_ff, rd_in;
   logic [whcrr_pkg::QPtrW:0]   count_ff, count_in;
   logic                        do_push, do_pop;

   assign full    = (count_ff == (whcrr_pkg::QPtrW+1)'(whcrr_pkg::QDepth));
   assign empty   = (count_ff == '0);
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign head    = mem_ff[rd_ff];

   always_comb begin
      wr_in    = do_push ? wr_ff + 1'b1 : wr_ff;
      rd_in    = do_pop ? rd_ff + 1'b1 : rd_ff;
      count_in = count_ff;
      if (do_push && !do_pop) count_in = count_ff + 1'b1;
      if (do_pop && !do_push) count_in = count_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= '0;
         rd_ff    <= '0;
         count_ff <= '0;
      end else begin
         wr_ff    <= wr_in;
         rd_ff    <= rd_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) mem_ff[wr_ff] <= push_job;
   end

endmodule

// ===== rtl/core/whcrr_back.sv =====
// back end: walks the head job beat by beat onto the result stream
// depends on whcrr_pkg

module whcrr_back (
   input  logic                clock,
   input  logic                reset,
   input  logic                q_empty,
   input  whcrr_pkg::job_type  q_head,
   output logic                q_pop,
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   output logic [7:0]          rsp_tdata,   // [7:0] out_byte
   output logic [4:0]          rsp_tuser,   // [0] out_valid, [4:1] status
   output logic                rsp_tlast    // last_of_run
);

   logic [1:0] beat_ff, beat_in;
   logic       take;

   assign rsp_tvalid = !q_empty;
   assign rsp_tdata  = q_head.data_ok ? q_head.bytes[beat_ff] : 8'd0;
   assign rsp_tuser  = {q_head.status, q_head.data_ok};
   assign rsp_tlast  = (beat_ff == q_head.last_idx);
   assign take       = rsp_tvalid && rsp_tready;
   assign q_pop      = take && rsp_tlast;

   always_comb begin
      beat_in = beat_ff;
      if (take) beat_in = rsp_tlast ? 2'd0 : beat_ff + 2'd1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         beat_ff <= 2'd0;
      end else begin
         beat_ff <= beat_in;
      end
   end

endmodule

// ===== rtl/core/wav_header_check_and_rate_rewrite.sv =====
// top level of the wav header checker and rate rewriter
// depends on whcrr_pkg, whcrr_front, whcrr_queue, whcrr_back

// Takes a WAV file one byte per beat on req_ (tlast marks the file's final byte)
// and checks the 44-byte RIFF/WAVE/fmt/data header. Every input byte yields one
// to four result beats on rsp_; the last of them carries tlast, and all of them
// carry the status found by that byte in tuser. A byte that yields nothing to
// emit still gives one beat with out_valid low and data zero. Mode 1 (or 0)
// only checks, including total file length against the RIFF size; modes 2 and
// 3 copy the file, replacing sample rate and byte rate by their half or double.
// After an error the rest of the file is copied unchanged (modes 2 and 3) or
// dropped (mode 1). Input is taken at one byte per cycle while the queue has room;
// output runs at one beat per cycle while rsp_tready is high, so the fourth byte of
// each rate field, which gives four beats, can hold input off once the four-entry
// job queue between parser and result sequencer fills. The mode register sits at
// byte address 0 of the csr_ port and should be written only while idle.

module wav_header_check_and_rate_rewrite (
   input  logic                          clock,
   input  logic                          reset,
   // input byte stream
   input  logic                          req_tvalid,
   output logic                          req_tready,
   input  logic [7:0]                    req_tdata,   // [7:0] in_byte
   input  logic                          req_tlast,   // end_of_file
   // result stream
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   output logic [7:0]                    rsp_tdata,   // [7:0] out_byte
   output logic [4:0]                    rsp_tuser,   // [0] out_valid, [4:1] status
   output logic                          rsp_tlast,   // last_of_run
   // configuration
   input  logic                          csr_psel,
   input  logic                          csr_penable,
   input  logic                          csr_pwrite,
   input  logic [whcrr_pkg::CsrAddrW-1:0] csr_paddr,
   input  logic [31:0]                   csr_pwdata,
   output logic [31:0]                   csr_prdata,
   output logic                          csr_pready
);

   logic [1:0]          mode_ff, mode_in;
   logic                csr_wr, csr_hit;
   logic                q_full, q_push, q_pop, q_empty;
   whcrr_pkg::job_type  q_job, q_head;

   // config register: single-word map, mode in the low two bits
   assign csr_pready = 1'b1;
   assign csr_hit    = (csr_paddr[whcrr_pkg::CsrAddrW-1:2] == whcrr_pkg::RegMode);
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_prdata = csr_hit ? {30'd0, mode_ff} : 32'd0;

   always_comb begin
      mode_in = mode_ff;
      if (csr_wr && csr_hit) mode_in = csr_pwdata[1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= whcrr_pkg::ModeCheck;
      end else begin
         mode_ff <= mode_in;
      end
   end

   // parser: one job per accepted byte
   whcrr_front u_front (
      .clock      (clock),
      .reset      (reset),
      .mode       (mode_ff),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .q_full     (q_full),
      .q_push     (q_push),
      .q_job      (q_job)
   );

   // decouples parsing from beat output
   whcrr_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (q_push),
      .push_job (q_job),
      .full     (q_full),
      .pop      (q_pop),
      .empty    (q_empty),
      .head     (q_head)
   );

   // result sequencer: one beat per cycle while a job is queued and rsp_tready is high
   whcrr_back u_back (
      .clock      (clock),
      .reset      (reset),
      .q_empty    (q_empty),
      .q_head     (q_head),
      .q_pop      (q_pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   // a beat without stream data is always the only beat of its run, data zero
   a_empty_beat_alone : assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser[0] |-> rsp_tlast && rsp_tdata == 8'd0)
      else $error("empty result beat not alone or data nonzero");

   // beats of one run share their flag and status
   a_run_status_stable : assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tready && !rsp_tlast |=> rsp_tvalid && $stable(rsp_tuser))
      else $error("status changed inside a run");

   // after every accepted byte the result stream holds a beat on the next cycle
   a_accept_gives_result : assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> rsp_tvalid)
      else $error("accepted byte left no result");

endmodule

// ===== bench/tb_wav_header_check_and_rate_rewrite.sv =====
// self-checking bench for wav_header_check_and_rate_rewrite: random wav files in all modes
// depends on whcrr_pkg and the rtl top level; predicts every result beat in sv
`timescale 1ns / 100ps

module tb_wav_header_check_and_rate_rewrite;

   localparam int CycleLimit  = 400000;
   localparam int DrainCycles = 12;
   localparam int PhaseBytes  = 20;
   localparam int CsrAw       = whcrr_pkg::CsrAddrW;

   // mode value the block must treat as check only
   localparam logic [1:0] ModeZero = 2'd0;

   // header tags, first byte in the lowest bits like every little-endian field
   localparam logic [31:0] TagRiff = {8'd70, 8'd70, 8'd73, 8'd82};
   localparam logic [31:0] TagWave = {8'd69, 8'd86, 8'd65, 8'd87};
   localparam logic [31:0] TagFmt  = {8'd32, 8'd116, 8'd109, 8'd102};
   localparam logic [31:0] TagData = {8'd97, 8'd116, 8'd97, 8'd100};
   localparam logic [31:0] FmtSizePcm = 32'd16;
   localparam logic [15:0] FmtPcm     = 16'd1;

   // one byte of a file as the sender sees it
   typedef struct packed {
      logic [7:0] value;
      logic       eof;
   } file_byte_type;

   // one result beat as the receiver sees it
   typedef struct packed {
      logic [7:0] data;
      logic       flag;
      logic [3:0] status;
      logic       last;
   } wav_beat_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata = '0;   // [7:0] in_byte
   logic        req_tlast = 1'b0; // end_of_file
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b1;
   logic [7:0]  rsp_tdata;        // [7:0] out_byte
   logic [4:0]  rsp_tuser;        // [0] out_valid, [4:1] status
   logic        rsp_tlast;        // last_of_run
   logic        csr_psel = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite = 1'b0;
   logic [CsrAw-1:0] csr_paddr = '0;
   logic [31:0] csr_pwdata = '0;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   wav_header_check_and_rate_rewrite i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tlast   (req_tlast),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .rsp_tlast   (rsp_tlast),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   // stimulus and scoreboard storage
   file_byte_type bytes_to_send[$];
   wav_beat_type  beats_due[$];
   logic [7:0] file_buf[$];
   logic       req_fire = 1'b0;
   int         send_idle_pct = 0;
   int         stall_pct = 0;
   int         mismatch_count = 0;
   int         cycle_count = 0;

   // shadow of the block's mode register and per-file parser state
   logic [1:0]  cur_mode = whcrr_pkg::ModeCheck;
   logic [5:0]  hdr_pos;
   logic [31:0] riff_sz;
   logic [31:0] fmt_sz;
   logic [15:0] fmt_code;
   logic [15:0] chans;
   logic [31:0] srate;
   logic [31:0] brate;
   logic [15:0] balign;
   logic [15:0] bps;
   logic        stopped;
   logic [31:0] file_len;

   initial begin
      forever #4 clock = ~clock;
   end

   // back to the start-of-file state, also done after every final byte
   task automatic clear_file();
      hdr_pos  = '0;
      riff_sz  = '0;
      fmt_sz   = '0;
      fmt_code = '0;
      chans    = '0;
      srate    = '0;
      brate    = '0;
      balign   = '0;
      bps      = '0;
      stopped  = 1'b0;
      file_len = '0;
   endtask

   // works out the result beats of one accepted input byte
   task automatic predict_wav_byte(input logic [7:0] b, input logic eof);
      logic [1:0]  m;
      logic        copy;
      logic [7:0]  emit[$];
      logic [3:0]  st;
      logic [32:0] want_len;
      logic [5:0]  pos;
      logic        keep;
      logic        have_rw;
      logic [31:0] rw;
      logic [63:0] prod;
      m = (cur_mode == ModeZero) ? whcrr_pkg::ModeCheck : cur_mode;
      copy = (m == whcrr_pkg::ModeHalve || m == whcrr_pkg::ModeDouble);
      st = whcrr_pkg::StOk;
      want_len = {1'b0, riff_sz} + 33'd8;
      if (file_len != 32'hFFFF_FFFF) file_len++;

      if (stopped) begin
         // after an error: pass through in copy modes, drop in check mode
         if (copy) emit.push_back(b);
      end else if (hdr_pos < whcrr_pkg::HdrLen) begin
         pos = hdr_pos + 6'd1;
         keep = copy;
         have_rw = 1'b0;
         rw = '0;
         hdr_pos = pos;
         if (pos <= 4) begin
            if (b != TagRiff[8*(pos-1) +: 8]) st = whcrr_pkg::StRiff;
         end else if (pos <= 8) begin
            riff_sz[8*(pos-5) +: 8] = b;
         end else if (pos <= 12) begin
            if (b != TagWave[8*(pos-9) +: 8]) st = whcrr_pkg::StWave;
         end else if (pos <= 16) begin
            if (b != TagFmt[8*(pos-13) +: 8]) st = whcrr_pkg::StFmtTag;
         end else if (pos <= 20) begin
            fmt_sz[8*(pos-17) +: 8] = b;
            if (pos == 20 && fmt_sz != FmtSizePcm) st = whcrr_pkg::StFmtSize;
         end else if (pos <= 22) begin
            fmt_code[8*(pos-21) +: 8] = b;
            if (pos == 22 && fmt_code != FmtPcm) st = whcrr_pkg::StNotPcm;
         end else if (pos <= 24) begin
            chans[8*(pos-23) +: 8] = b;
            if (pos == 24 && chans != 16'd1 && chans != 16'd2) st = whcrr_pkg::StChannels;
         end else if (pos <= 28) begin
            // rate bytes are held back and replaced on the field's last byte
            srate[8*(pos-25) +: 8] = b;
            keep = 1'b0;
            if (pos == 28) begin
               rw = (m == whcrr_pkg::ModeDouble) ? (srate << 1) : (srate >> 1);
               have_rw = 1'b1;
            end
         end else if (pos <= 32) begin
            brate[8*(pos-29) +: 8] = b;
            keep = 1'b0;
            if (pos == 32) begin
               rw = (m == whcrr_pkg::ModeDouble) ? (brate << 1) : (brate >> 1);
               have_rw = 1'b1;
            end
         end else if (pos <= 34) begin
            // block align goes out even when its check fails
            balign[8*(pos-33) +: 8] = b;
            if (copy) emit.push_back(b);
            keep = 1'b0;
            prod = {32'd0, srate} * {48'd0, balign};
            if (pos == 34 && {32'd0, brate} != prod) st = whcrr_pkg::StByteRate;
         end else if (pos <= 36) begin
            bps[8*(pos-35) +: 8] = b;
            if (copy) emit.push_back(b);
            keep = 1'b0;
            if (pos == 36 && {16'd0, balign} != 32'(bps >> 3) * 32'(chans))
               st = whcrr_pkg::StBlockAlign;
         end else if (pos <= 40) begin
            // a bad data tag reports like a bad fmt tag
            if (b != TagData[8*(pos-37) +: 8]) st = whcrr_pkg::StFmtTag;
         end

         if (st != whcrr_pkg::StOk) begin
            stopped = 1'b1;
         end else begin
            if (keep) emit.push_back(b);
            if (have_rw && copy) begin
               for (int k = 0; k < 4; k++) emit.push_back(rw[8*k +: 8]);
            end
            if (pos == whcrr_pkg::HdrLen && m == whcrr_pkg::ModeCheck && eof &&
                {1'b0, file_len} != want_len)
               st = whcrr_pkg::StFileSize;
            if (pos < whcrr_pkg::HdrLen && eof) st = whcrr_pkg::StTrunc;
         end
      end else begin
         // payload: length against the riff size in check mode only
         if (copy) begin
            emit.push_back(b);
         end else if ({1'b0, file_len} > want_len) begin
            st = whcrr_pkg::StFileSize;
            stopped = 1'b1;
         end else if (eof && {1'b0, file_len} != want_len) begin
            st = whcrr_pkg::StFileSize;
         end
      end

      if (emit.size() == 0) begin
         beats_due.push_back('{8'd0, 1'b0, st, 1'b1});
      end else begin
         foreach (emit[k]) beats_due.push_back('{emit[k], 1'b1, st, k == emit.size() - 1});
      end
      if (eof) clear_file();
   endtask

   // apb write: setup cycle then access cycle, pready is tied high
   task automatic csr_write(input logic [CsrAw-1:0] addr, input logic [31:0] value);
      @(negedge clock);
      csr_psel    <= 1'b1;
      csr_pwrite  <= 1'b1;
      csr_penable <= 1'b0;
      csr_paddr   <= addr;
      csr_pwdata  <= value;
      @(negedge clock);
      csr_penable <= 1'b1;
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      cur_mode = value[1:0];
   endtask

   task automatic push_le(input logic [31:0] v, input int nb);
      for (int k = 0; k < nb; k++) file_buf.push_back(v[8*k +: 8]);
   endtask

   // hand the first n bytes of file_buf to the driver, final one flagged
   task automatic queue_file(input int n);
      for (int i = 0; i < n; i++) bytes_to_send.push_back('{file_buf[i], i == n - 1});
   endtask

   // some well-formed files; the rest corrupted, cut short, overlong or noise
   task automatic gen_file(output int n);
      logic [31:0] sr;
      logic [31:0] br;
      logic [31:0] rs;
      logic [15:0] ch;
      logic [15:0] bits;
      logic [15:0] ba;
      int          data_len;
      int          kind;
      int          spot;
      int          cut;
      ch = 16'($urandom_range(1, 2));
      bits = 16'(8 * $urandom_range(1, 4));
      ba = (bits >> 3) * ch;
      // huge rates overflow the byte rate product and when doubled
      sr = ($urandom_range(3) == 0) ? $urandom : $urandom_range(1, 96000);
      br = sr * ba;
      data_len = $urandom_range(0, 6);
      rs = 32'(36 + data_len);
      kind = $urandom_range(9);
      file_buf.delete();
      if (kind == 0) begin
         n = $urandom_range(1, 6);
         repeat (n) file_buf.push_back(8'($urandom));
         if ($urandom_range(1) == 1) file_buf[0] = TagRiff[7:0];
      end else begin
         push_le(TagRiff, 4);
         push_le(rs, 4);
         push_le(TagWave, 4);
         push_le(TagFmt, 4);
         push_le(FmtSizePcm, 4);
         push_le(FmtPcm, 2);
         push_le(ch, 2);
         push_le(sr, 4);
         push_le(br, 4);
         push_le(ba, 2);
         push_le(bits, 2);
         push_le(TagData, 4);
         push_le(32'(data_len), 4);
         repeat (data_len) file_buf.push_back(8'($urandom));
         n = file_buf.size();
         if (kind >= 5 && kind <= 7) begin
            // flip bits of one header byte, then end the file soon after
            spot = $urandom_range(0, 43);
            file_buf[spot] = file_buf[spot] ^ 8'($urandom_range(1, 255));
            cut = spot + 1 + $urandom_range(0, 3);
            if (cut < n) n = cut;
         end else if (kind == 8) begin
            n = $urandom_range(1, 43);
         end else if (kind == 9) begin
            repeat ($urandom_range(1, 3)) file_buf.push_back(8'($urandom));
            n = file_buf.size();
         end else if (kind == 4 && data_len > 0) begin
            n = n - 1;
         end
      end
      queue_file(n);
   endtask

   // waits until every byte is taken and every beat has come back
   task automatic drain();
      while (bytes_to_send.size() != 0 || req_tvalid || beats_due.size() != 0)
         @(posedge clock);
      repeat (DrainCycles) @(negedge clock);
   endtask

   task automatic run_phase(input logic [1:0] m, input int send_idle, input int stall);
      int queued;
      int n;
      csr_write(CsrAw'(4 * whcrr_pkg::RegMode), {30'd0, m});
      send_idle_pct = send_idle;
      stall_pct = stall;
      queued = 0;
      while (queued < PhaseBytes) begin
         gen_file(n);
         queued += n;
      end
      drain();
   endtask

   // sender: a new beat only once the current one is taken or none is up
   always @(negedge clock) begin
      file_byte_type nxt;
      if (!reset) begin
         if (!req_tvalid || req_fire) begin
            if (bytes_to_send.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
               nxt = bytes_to_send.pop_front();
               req_tvalid <= 1'b1;
               req_tdata  <= nxt.value;
               req_tlast  <= nxt.eof;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
         rsp_tready <= ($urandom_range(99) >= stall_pct);
      end
   end

   // receiver and scoreboard: check result beats, then predict taken bytes
   always @(posedge clock) begin
      wav_beat_type got;
      wav_beat_type want;
      req_fire <= req_tvalid && req_tready;
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            got = '{rsp_tdata, rsp_tuser[0], rsp_tuser[4:1], rsp_tlast};
            if (beats_due.size() == 0) begin
               mismatch_count++;
               $display("%0t: unexpected beat data %h valid %b status %0d last %b",
                        $time, got.data, got.flag, got.status, got.last);
            end else begin
               want = beats_due.pop_front();
               if (got !== want) begin
                  mismatch_count++;
                  $display("%0t: beat mismatch exp data %h valid %b status %0d last %b",
                           $time, want.data, want.flag, want.status, want.last);
                  $display("%0t:                got data %h valid %b status %0d last %b",
                           $time, got.data, got.flag, got.status, got.last);
               end
            end
         end
         if (req_tvalid && req_tready) predict_wav_byte(req_tdata, req_tlast);
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CycleLimit) begin
         $display("%0t: timeout, %0d beats outstanding", $time, beats_due.size());
         $display("FAILURE");
         $finish;
      end
   end

   initial begin
      clear_file();
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: one-byte files, bad riff tag, and a header with maximal riff size
      // and a bad fmt tag, cut short, whose later bytes are dropped after the error
      csr_write(CsrAw'(4 * whcrr_pkg::RegMode), {30'd0, whcrr_pkg::ModeCheck});
      file_buf = '{8'h00};
      queue_file(1);
      file_buf = '{8'hFF};
      queue_file(1);
      file_buf = '{TagRiff[7:0]};
      queue_file(1);
      file_buf.delete();
      push_le({8'd88, TagRiff[23:0]}, 4);
      queue_file(4);
      file_buf.delete();
      push_le(TagRiff, 4);
      push_le(32'hFFFF_FFFF, 4);
      push_le(TagWave, 4);
      push_le(TagFmt & 32'h00FF_FFFF, 4);
      file_buf.push_back(8'h00);
      file_buf.push_back(8'hFF);
      queue_file(18);
      drain();

      // random files across modes and handshake pressure
      run_phase(whcrr_pkg::ModeCheck,  0,  0);
      run_phase(whcrr_pkg::ModeHalve,  0,  0);
      run_phase(whcrr_pkg::ModeDouble, 84, 0);
      run_phase(whcrr_pkg::ModeCheck,  0,  84);
      run_phase(whcrr_pkg::ModeHalve,  14, 14);
      run_phase(ModeZero,              84, 0);
      run_phase(whcrr_pkg::ModeDouble, 0,  84);
      run_phase(whcrr_pkg::ModeCheck,  14, 14);

      if (mismatch_count == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule
